// ===== design/frame_deframer_with_checksum_assert.svh =====
// Assertion helpers for the frame deframer.
// Each macro expects signals named clock and reset in the using module.
`ifndef FRAME_DEFRAMER_WITH_CHECKSUM_ASSERT_SVH
`define FRAME_DEFRAMER_WITH_CHECKSUM_ASSERT_SVH

// Same-cycle implication.
`define FDC_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define FDC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/fdc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package fdc_pkg;

   // Event codes on the result channel
   localparam logic [2:0] EV_PAYLOAD  = 3'd0;
   localparam logic [2:0] EV_GOOD     = 3'd1;
   localparam logic [2:0] EV_BAD_SUM  = 3'd2;
   localparam logic [2:0] EV_OVERSIZE = 3'd3;
   localparam logic [2:0] EV_TIMEOUT  = 3'd4;

   // Input action codes
   localparam logic ACT_BYTE = 1'b0;
   localparam logic ACT_TICK = 1'b1;

   localparam logic [7:0]  START_BYTE      = 8'hAA;
   localparam logic [15:0] TIMEOUT_RESET   = 16'd50;
   localparam logic [15:0] IDLE_TICKS_MAX  = 16'hFFFF;

   // Register map
   localparam logic REG_TIMEOUT = 1'b0;

   // One result beat from the parser to the output register
   typedef struct packed {
      logic        valid;
      logic [2:0]  event_res;
      logic [7:0]  command;
      logic [11:0] payload_length;
      logic [10:0] byte_index;
      logic [7:0]  payload_byte;
      logic        last;
   } fdc_result_type;

endpackage

`default_nettype wire

// ===== design/fdc_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Input byte/tick channel
interface fdc_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] rx_byte;

   modport source (output valid, output action, output rx_byte, input ready);
   modport sink (input valid, input action, input rx_byte, output ready);
endinterface

`default_nettype wire

// ===== design/fdc_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Result event channel
interface fdc_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  event_res;
   logic [7:0]  command;
   logic [11:0] payload_length;
   logic [10:0] byte_index;
   logic [7:0]  payload_byte;
   logic        last;

   modport source (output valid, output event_res, output command, output payload_length,
                   output byte_index, output payload_byte, output last, input ready);
   modport sink (input valid, input event_res, input command, input payload_length,
                 input byte_index, input payload_byte, input last, output ready);
endinterface

`default_nettype wire

// ===== design/fdc_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "frame_deframer_with_checksum_assert.svh"

// Frame state and one-byte step; result is combinational from the accepted beat
module fdc_parser
   import fdc_pkg::*;
#(
   parameter int MAX_PAYLOAD = 2048
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        step,
   input  wire logic        action,
   input  wire logic [7:0]  rx_byte,
   input  wire logic [15:0] timeout_ms,
   output fdc_result_type   res
);

   localparam int CW = $clog2(MAX_PAYLOAD + 5);

   logic [CW-1:0] count_ff, count_in;
   logic [7:0]    cmd_ff, cmd_in;
   logic [15:0]   len_ff, len_in;
   logic [7:0]    sum_ff, sum_in;
   logic [15:0]   idle_ticks_ff, idle_ticks_in;

   logic          timed_out;
   logic [16:0]   pos_wide;
   logic [16:0]   frame_end;
   logic [16:0]   idx_wide;
   logic [15:0]   len_full;

   // Next-state and result
   always_comb begin
      count_in      = count_ff;
      cmd_in        = cmd_ff;
      len_in        = len_ff;
      sum_in        = sum_ff;
      idle_ticks_in = idle_ticks_ff;
      res           = '0;

      timed_out = (count_ff != '0) && (idle_ticks_ff > timeout_ms);
      pos_wide  = 17'(count_ff);
      frame_end = {1'b0, len_ff} + 17'd4;
      idx_wide  = pos_wide - 17'd4;
      len_full  = {rx_byte, len_ff[7:0]};

      if (step) begin
         if (action == ACT_TICK) begin
            if (idle_ticks_ff != IDLE_TICKS_MAX) begin
               idle_ticks_in = idle_ticks_ff + 16'd1;
            end
         end else begin
            idle_ticks_in = '0;
            if (timed_out || count_ff == '0) begin
               // Drop of the partial frame, then hunt with this byte
               if (timed_out) begin
                  res.valid          = 1'b1;
                  res.event_res      = EV_TIMEOUT;
                  res.command        = cmd_ff;
                  res.payload_length = (count_ff >= CW'(4)) ? len_ff[11:0] : 12'd0;
                  res.last           = 1'b1;
               end
               cmd_in   = '0;
               len_in   = '0;
               if (rx_byte == START_BYTE) begin
                  count_in = CW'(1);
                  sum_in   = START_BYTE;
               end else begin
                  count_in = '0;
                  sum_in   = '0;
               end
            end else begin
               count_in = count_ff + CW'(1);
               sum_in   = sum_ff + rx_byte;
               if (count_ff == CW'(1)) begin
                  cmd_in = rx_byte;
               end else if (count_ff == CW'(2)) begin
                  len_in = {8'd0, rx_byte};
               end else if (count_ff == CW'(3)) begin
                  len_in = len_full;
                  if (len_full > 16'(MAX_PAYLOAD)) begin
                     res.valid     = 1'b1;
                     res.event_res = EV_OVERSIZE;
                     res.command   = cmd_ff;
                     res.last      = 1'b1;
                     count_in      = '0;
                     cmd_in        = '0;
                     len_in        = '0;
                     sum_in        = '0;
                  end
               end else if (pos_wide < frame_end) begin
                  // Payload byte
                  res.valid          = 1'b1;
                  res.event_res      = EV_PAYLOAD;
                  res.command        = cmd_ff;
                  res.payload_length = len_ff[11:0];
                  res.byte_index     = idx_wide[10:0];
                  res.payload_byte   = rx_byte;
               end else begin
                  // Checksum byte closes the frame
                  res.valid          = 1'b1;
                  res.event_res      = (rx_byte == sum_ff) ? EV_GOOD : EV_BAD_SUM;
                  res.command        = cmd_ff;
                  res.payload_length = len_ff[11:0];
                  res.last           = 1'b1;
                  count_in           = '0;
                  cmd_in             = '0;
                  len_in             = '0;
                  sum_in             = '0;
               end
            end
         end
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         cmd_ff        <= '0;
         len_ff        <= '0;
         sum_ff        <= '0;
         idle_ticks_ff <= '0;
      end else begin
         count_ff      <= count_in;
         cmd_ff        <= cmd_in;
         len_ff        <= len_in;
         sum_ff        <= sum_in;
         idle_ticks_ff <= idle_ticks_in;
      end
   end

   `FDC_ASSERT_IMPL(a_hunt_silent, step && (count_ff == '0), !res.valid, "result while hunting")
   `FDC_ASSERT_NEXT(a_end_idle, res.valid && res.last, count_ff <= CW'(1), "frame not closed")
   `FDC_ASSERT_NEXT(a_byte_clears_idle, step && (action == ACT_BYTE), idle_ticks_ff == '0,
                    "idle count not cleared")
   `FDC_ASSERT_IMPL(a_payload_in_body, res.valid && (res.event_res == EV_PAYLOAD),
                    (count_ff >= CW'(4)) && !res.last, "payload outside frame body")

endmodule

`default_nettype wire

// ===== design/frame_deframer_with_checksum.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Frame deframer with additive checksum.
// req_bus carries one beat per received byte (action 0) or per millisecond
// tick (action 1). Frames are 0xAA, command, 16-bit little-endian length,
// payload, then an 8-bit sum of all earlier frame bytes. rsp_bus carries one
// beat per payload byte and one closing beat (good, bad checksum, oversize or
// timeout drop) with last set; ticks and non-oversize header bytes give no beat.
// Latency: a result is valid in the cycle after its input beat is taken.
// Throughput: one input beat per cycle when not stalled; the parser step
// is a single registered pass; the output register holds one pending result.
// When the receiver stalls, the pending result holds and req_bus.ready drops
// until rsp_bus.ready frees the output register in the same cycle.
// Reset: synchronous; the parser hunts for a start byte, the idle tick count
// is zero, timeout_ms is 50 and no result is pending.
// The APB-style port holds timeout_ms at address 0; write it only when idle.
module frame_deframer_with_checksum
   import fdc_pkg::*;
#(
   parameter int MAX_PAYLOAD = 2048
) (
   input  wire logic        clock,
   input  wire logic        reset,
   fdc_req_if.sink          req_bus,
   fdc_rsp_if.source        rsp_bus,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   logic [15:0]    timeout_ff;
   logic           step;
   fdc_result_type res;
   fdc_result_type out_ff;

   // Config register
   assign pready = 1'b1;
   assign prdata = (paddr[2] == REG_TIMEOUT) ? {16'd0, timeout_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
      end else if (psel && penable && pwrite && pready && (paddr[2] == REG_TIMEOUT)) begin
         timeout_ff <= pwdata[15:0];
      end
   end

   // Input handshake: take a beat whenever the output register can move
   assign req_bus.ready = !out_ff.valid || rsp_bus.ready;
   assign step          = req_bus.valid && req_bus.ready;

   fdc_parser #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .action     (req_bus.action),
      .rx_byte    (req_bus.rx_byte),
      .timeout_ms (timeout_ff),
      .res        (res)
   );

   // Output register; only the valid flag is reset
   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else if (req_bus.ready) begin
         out_ff.valid <= res.valid;
      end
      if (req_bus.ready && res.valid) begin
         out_ff.event_res      <= res.event_res;
         out_ff.command        <= res.command;
         out_ff.payload_length <= res.payload_length;
         out_ff.byte_index     <= res.byte_index;
         out_ff.payload_byte   <= res.payload_byte;
         out_ff.last           <= res.last;
      end
   end

   assign rsp_bus.valid          = out_ff.valid;
   assign rsp_bus.event_res      = out_ff.event_res;
   assign rsp_bus.command        = out_ff.command;
   assign rsp_bus.payload_length = out_ff.payload_length;
   assign rsp_bus.byte_index     = out_ff.byte_index;
   assign rsp_bus.payload_byte   = out_ff.payload_byte;
   assign rsp_bus.last           = out_ff.last;

endmodule

`default_nettype wire
